>>> rtl/core/grid_to_cartesian_trilinear_defines.svh
// Assertion macros shared by the grid-to-cartesian RTL.
// No dependencies.
`ifndef GRID_TO_CARTESIAN_TRILINEAR_DEFINES_SVH
`define GRID_TO_CARTESIAN_TRILINEAR_DEFINES_SVH
// Checks that a condition implies a consequence in the next cycle.
`define G2C_ASSERT_NEXT(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("g2c assertion failed");
// Checks that a condition implies a consequence in the same cycle.
`define G2C_ASSERT_NOW(lbl, clk, rst, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("g2c assertion failed");
`endif

>>> rtl/core/g2c_pkg.sv
// Package for the grid-to-cartesian block: constants, commands, states, control structs.
// No dependencies.
package g2c_pkg;
  localparam int SEGMENTS_DEF = 64;
  localparam int GRID_R_DEF = 32;
  localparam int GRID_P_DEF = 16;
  localparam int GRID_Z_DEF = 32;
  localparam int BASIS_POINTS_DEF = 32768;
  localparam int FRACTION_BITS_DEF = 8;

  typedef enum logic [1:0] {
    CMD_LIMITS = 2'd0,
    CMD_CELL   = 2'd1,
    CMD_BASIS  = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    OUT_INTERP   = 2'd0,
    OUT_NEAREST  = 2'd1,
    OUT_FAILED   = 2'd2
  } outcome_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LIM, ST_SETUP, ST_CORNER, ST_CWAIT, ST_MOVE,
    ST_FRAC, ST_WMUL1, ST_WMUL2, ST_BREAD, ST_ACC, ST_FINISH,
    ST_NEAR, ST_NWAIT, ST_NBASIS, ST_DONE
  } state_t;

  typedef struct packed {
    logic write;      // perform a table write from the latched command
    logic capture;    // latch input item
    logic lim_read;   // read segment limits
    logic setup;      // range check and integer parts
    logic cell_read;  // read grid cell of current corner
    logic cell_check; // evaluate cell read for corner
    logic move;       // shift cell toward middle
    logic frac;       // compute fractions
    logic wmul1;      // fr*fp
    logic wmul2;      // *fz
    logic basis_read; // read basis of current corner
    logic acc;        // accumulate one coordinate
    logic finish;     // final rounding
    logic near_setup; // clamp to nearest point
    logic near_read;  // address basis memory with the nearest cell's entry
    logic near_basis; // read basis of nearest point
    logic clr_corner; // corner counter to zero
    logic inc_corner;
  } ctl_t;

  typedef struct packed {
    logic       is_write;
    logic       seg_bad;
    logic       range_ok;
    logic       cell_ok;
    logic       last_corner;
    logic       last_try;
    logic [1:0] coord;  // coordinate in accumulation
  } sts_t;
endpackage

>>> rtl/core/g2c_ctrl.sv
// Controller state machine for the grid-to-cartesian block.
// Depends on g2c_pkg and the assertion macros header.
`include "grid_to_cartesian_trilinear_defines.svh"
module g2c_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output logic [1:0]    res_code,
  output g2c_pkg::ctl_t ctl,
  input  g2c_pkg::sts_t sts
);
  import g2c_pkg::*;

  state_t state, state_next;
  logic [1:0] code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      code  <= OUT_INTERP;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next = state;
    code_next = code;
    unique case (state)
      ST_IDLE: if (start) state_next = ST_LIM;
      ST_LIM: begin
        if (sts.is_write) begin
          state_next = ST_DONE;
          code_next = OUT_INTERP;
        end else if (sts.seg_bad) begin
          state_next = ST_DONE;
          code_next = OUT_FAILED;
        end else state_next = ST_SETUP;
      end
      ST_SETUP: state_next = sts.range_ok ? ST_CORNER : ST_NEAR;
      ST_CORNER: state_next = ST_CWAIT;
      ST_CWAIT: begin
        if (!sts.cell_ok) state_next = sts.last_try ? ST_NEAR : ST_MOVE;
        else if (sts.last_corner) state_next = ST_FRAC;
        else state_next = ST_CORNER;
      end
      ST_MOVE: state_next = ST_CORNER;
      ST_FRAC: state_next = ST_WMUL1;
      ST_WMUL1: state_next = ST_WMUL2;
      ST_WMUL2: state_next = ST_BREAD;
      ST_BREAD: state_next = ST_ACC;
      ST_ACC: begin
        if (sts.coord == 2'd2)
          state_next = sts.last_corner ? ST_FINISH : ST_WMUL1;
      end
      ST_FINISH: begin
        state_next = ST_DONE;
        code_next = OUT_INTERP;
      end
      ST_NEAR: state_next = ST_NWAIT;
      ST_NWAIT: begin
        if (sts.cell_ok) state_next = ST_NBASIS;
        else begin
          state_next = ST_DONE;
          code_next = OUT_FAILED;
        end
      end
      ST_NBASIS: begin
        state_next = ST_DONE;
        code_next = OUT_NEAREST;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = (state != ST_IDLE);
    done = (state == ST_DONE);
    res_code = code;
    unique case (state)
      ST_IDLE: ctl.capture = start;
      ST_LIM: begin
        ctl.lim_read = 1'b1;
        ctl.write = sts.is_write;
      end
      ST_SETUP: begin
        ctl.setup = 1'b1;
        ctl.clr_corner = 1'b1;
      end
      ST_CORNER: ctl.cell_read = 1'b1;
      ST_CWAIT: begin
        ctl.cell_check = 1'b1;
        ctl.inc_corner = sts.cell_ok && !sts.last_corner;
        ctl.clr_corner = !sts.cell_ok || sts.last_corner;
      end
      ST_MOVE: ctl.move = 1'b1;
      ST_FRAC: ctl.frac = 1'b1;
      ST_WMUL1: ctl.wmul1 = 1'b1;
      ST_WMUL2: ctl.wmul2 = 1'b1;
      ST_BREAD: ctl.basis_read = 1'b1;
      ST_ACC: begin
        ctl.acc = 1'b1;
        ctl.inc_corner = (sts.coord == 2'd2) && !sts.last_corner;
      end
      ST_FINISH: ctl.finish = 1'b1;
      ST_NEAR: ctl.near_setup = 1'b1;
      ST_NWAIT: ctl.near_read = 1'b1;
      ST_NBASIS: ctl.near_basis = 1'b1;
      ST_DONE: ;
      default: ;
    endcase
  end

  `G2C_ASSERT_NEXT(a_start_busy, clk, rst, (start && !busy), busy)
  `G2C_ASSERT_NEXT(a_done_idle, clk, rst, done, !done && !busy)
  `G2C_ASSERT_NOW(a_write_code, clk, rst, (ctl.write), sts.is_write)
endmodule

>>> rtl/core/g2c_datapath.sv
// Datapath for the grid-to-cartesian block: tables, corner walk, weights, accumulators.
// Depends on g2c_pkg and the assertion macros header.
`include "grid_to_cartesian_trilinear_defines.svh"
module g2c_datapath #(
  parameter int SEGMENTS = g2c_pkg::SEGMENTS_DEF,
  parameter int GRID_R = g2c_pkg::GRID_R_DEF,
  parameter int GRID_P = g2c_pkg::GRID_P_DEF,
  parameter int GRID_Z = g2c_pkg::GRID_Z_DEF,
  parameter int BASIS_POINTS = g2c_pkg::BASIS_POINTS_DEF,
  parameter int FRACTION_BITS = g2c_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  g2c_pkg::ctl_t      ctl,
  output g2c_pkg::sts_t      sts,
  input  logic [1:0]         cmd,
  input  logic [5:0]         segment,
  input  logic signed [15:0] r_pos,
  input  logic signed [15:0] p_pos,
  input  logic signed [15:0] z_pos,
  input  logic [4:0]         grid_r,
  input  logic [3:0]         grid_p,
  input  logic [4:0]         grid_z,
  input  logic signed [15:0] entry_index,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z
);
  import g2c_pkg::*;

  localparam int SEGW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int RW = $clog2(GRID_R);
  localparam int PW = $clog2(GRID_P);
  localparam int ZW = $clog2(GRID_Z);
  localparam int BW = $clog2(BASIS_POINTS);
  localparam int CELLS = SEGMENTS * GRID_R * GRID_P * GRID_Z;
  localparam int AW = $clog2(CELLS);
  localparam int ONE = 1 << FRACTION_BITS;
  localparam int EPS = ONE / 10000;
  // factor width, signed; two moves can put the position up to 6 cells off
  localparam int FW = FRACTION_BITS + 4;

  // latched command
  logic [1:0] c_cmd;
  logic [5:0] c_seg;
  logic signed [15:0] v [3];
  logic [4:0] c_r, c_z;
  logic [3:0] c_p;
  logic signed [15:0] c_ent, c_x, c_y, c_zc;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      c_cmd <= cmd; c_seg <= segment;
      v[0] <= r_pos; v[1] <= p_pos; v[2] <= z_pos;
      c_r <= grid_r; c_p <= grid_p; c_z <= grid_z;
      c_ent <= entry_index; c_x <= coord_x; c_y <= coord_y; c_zc <= coord_z;
    end
  end

  logic seg_ok;
  assign seg_ok = ({26'd0, c_seg} < SEGMENTS);

  // memories
  logic [13:0] lim_mem [SEGMENTS];
  logic [15:0] grid_mem [CELLS];
  logic [47:0] basis_mem [BASIS_POINTS];
  logic [13:0] lim_q;
  logic [15:0] grid_q;
  logic [47:0] basis_q;
  logic [AW-1:0] grid_ra;
  logic [BW-1:0] basis_ra;
  logic        cell_inb, cell_inb_q;

  logic cell_wr_ok;
  assign cell_wr_ok = seg_ok && ({27'd0, c_r} < GRID_R) && ({28'd0, c_p} < GRID_P)
                      && ({27'd0, c_z} < GRID_Z);
  logic [AW-1:0] cell_wa;
  assign cell_wa = AW'(((({26'd0, c_seg} * GRID_R + {27'd0, c_r}) * GRID_P
                   + {28'd0, c_p}) * GRID_Z) + {27'd0, c_z});

  always_ff @(posedge clk) begin
    if (ctl.write && c_cmd == CMD_LIMITS && seg_ok)
      lim_mem[c_seg[SEGW-1:0]] <= {c_z, c_p, c_r};
    if (ctl.lim_read) lim_q <= lim_mem[c_seg[SEGW-1:0]];
  end
  always_ff @(posedge clk) begin
    if (ctl.write && c_cmd == CMD_CELL && cell_wr_ok) grid_mem[cell_wa] <= c_ent;
    grid_q <= grid_mem[grid_ra];
  end
  always_ff @(posedge clk) begin
    if (ctl.write && c_cmd == CMD_BASIS && !c_ent[15] && ({16'd0, c_ent} < BASIS_POINTS))
      basis_mem[c_ent[BW-1:0]] <= {c_x, c_y, c_zc};
    basis_q <= basis_mem[basis_ra];
  end

  // limits
  logic signed [7:0] mx [3];
  assign mx[0] = {3'd0, lim_q[4:0]};
  assign mx[1] = {4'd0, lim_q[8:5]};
  assign mx[2] = {3'd0, lim_q[13:9]};

  // integer cell indices, signed narrow
  logic signed [9:0] ix [3];
  logic [2:0] corner;
  logic [1:0] tries;
  logic [1:0] coord;

  function automatic logic signed [9:0] int_part(input logic signed [15:0] val);
    logic signed [16:0] t;
    t = 17'(val) + 17'(EPS);
    int_part = t[16] ? 10'sd0 : 10'(t >>> FRACTION_BITS);
  endfunction

  logic signed [9:0] ip [3];
  logic rok;
  always_comb begin
    rok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      ip[a] = int_part(v[a]);
      if (32'(v[a]) < -ONE || 32'(v[a]) > (32'(mx[a]) + 1) * ONE) rok = 1'b0;
    end
  end

  // current cell address
  logic signed [9:0] cr, cp, cz;
  always_comb begin
    if (ctl.near_setup) begin
      cr = (ip[0] > 10'(mx[0])) ? 10'(mx[0]) : ip[0];
      cp = (ip[1] > 10'(mx[1])) ? 10'(mx[1]) : ip[1];
      cz = (ip[2] > 10'(mx[2])) ? 10'(mx[2]) : ip[2];
    end else begin
      cr = ix[0] + 10'(corner[2]);
      cp = ix[1] + 10'(corner[1]);
      cz = ix[2] + 10'(corner[0]);
    end
    cell_inb = !cr[9] && !cp[9] && !cz[9] && (32'(cr) < GRID_R) && (32'(cp) < GRID_P)
               && (32'(cz) < GRID_Z);
    grid_ra = AW'((((32'(c_seg) * GRID_R + 32'(cr)) * GRID_P + 32'(cp)) * GRID_Z)
              + 32'(cz));
  end

  logic [BW-1:0] idx [8];
  logic cell_good;
  assign cell_good = cell_inb_q && !grid_q[15] && ({16'd0, grid_q} < BASIS_POINTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= '0;
      tries <= '0;
      coord <= '0;
      cell_inb_q <= 1'b0;
    end else begin
      cell_inb_q <= cell_inb;
      if (ctl.setup) tries <= '0;
      if (ctl.move) tries <= tries + 2'd1;
      if (ctl.clr_corner) corner <= '0;
      else if (ctl.inc_corner) corner <= corner + 3'd1;
      if (ctl.acc) coord <= (coord == 2'd2) ? 2'd0 : coord + 2'd1;
      else if (ctl.setup) coord <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      for (int a = 0; a < 3; a++) ix[a] <= (ip[a] > 10'(mx[a]) - 10'sd1) ?
                                           10'(mx[a]) - 10'sd1 : ip[a];
    end
    if (ctl.move) begin
      ix[0] <= (ix[0] > 10'(mx[0] >>> 1)) ? ix[0] - 10'sd2 : ix[0] + 10'sd2;
      ix[2] <= (ix[2] > 10'(mx[2] >>> 1)) ? ix[2] - 10'sd2 : ix[2] + 10'sd2;
    end
    if (ctl.cell_check) idx[corner] <= grid_q[BW-1:0];
  end

  // weights and accumulation on one shared multiplier
  logic signed [FW-1:0] f [3][2];
  logic signed [2*FW+1:0] w1;
  logic signed [3*FW+2:0] w;
  logic signed [3*FW+20:0] acc [3];
  logic signed [23:0] m_a, m_b;
  logic signed [47:0] m_p;
  logic [2:0] k;
  assign k = corner;

  function automatic logic signed [63:0] rnd(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = x + 64'(ONE / 2);
    rnd = y >>> FRACTION_BITS;  // arithmetic shift equals floor
  endfunction

  always_comb begin
    m_a = '0; m_b = '0;
    if (ctl.wmul1) begin
      m_a = 24'(f[0][k[2]]); m_b = 24'(f[1][k[1]]);
    end else if (ctl.wmul2) begin
      m_a = 24'(w1); m_b = 24'(f[2][k[0]]);
    end else begin
      m_a = 24'(w);
      unique case (coord)
        2'd0: m_b = 24'($signed(basis_q[47:32]));
        2'd1: m_b = 24'($signed(basis_q[31:16]));
        default: m_b = 24'($signed(basis_q[15:0]));
      endcase
    end
    m_p = m_a * m_b;
  end

  logic signed [15:0] ox, oy, oz;
  function automatic logic signed [15:0] sat(input logic signed [63:0] x);
    if (x > 64'sd32767) sat = 16'sh7fff;
    else if (x < -64'sd32768) sat = 16'sh8000;
    else sat = x[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.frac) begin
      for (int a = 0; a < 3; a++) begin
        f[a][1] <= FW'(32'(v[a]) - 32'(ix[a]) * ONE);
        f[a][0] <= FW'(ONE - (32'(v[a]) - 32'(ix[a]) * ONE));
        acc[a] <= '0;
      end
    end
    if (ctl.wmul1) w1 <= (2*FW+2)'(rnd(64'(m_p)));
    if (ctl.wmul2) w <= (3*FW+3)'(rnd(64'(m_p)));
    if (ctl.acc) acc[coord] <= acc[coord] + (3*FW+21)'(m_p);
    if (ctl.capture) begin
      ox <= '0; oy <= '0; oz <= '0;
    end
    if (ctl.finish) begin
      ox <= sat(rnd(64'(acc[0])));
      oy <= sat(rnd(64'(acc[1])));
      oz <= sat(rnd(64'(acc[2])));
    end
    if (ctl.near_basis) begin
      ox <= basis_q[47:32]; oy <= basis_q[31:16]; oz <= basis_q[15:0];
    end
  end

  // nearest point: the checked cell entry addresses the basis table directly
  assign basis_ra = ctl.near_read ? grid_q[BW-1:0] : idx[k];
  assign pos_x = ox;
  assign pos_y = oy;
  assign pos_z = oz;

  assign sts.is_write = (c_cmd != CMD_QUERY);
  assign sts.seg_bad = !seg_ok;
  assign sts.range_ok = rok;
  assign sts.cell_ok = cell_good;
  assign sts.last_corner = (corner == 3'd7);
  assign sts.last_try = (tries == 2'd2);
  assign sts.coord = coord;

  `G2C_ASSERT_NEXT(a_move_try, clk, rst, ctl.move, tries != 2'd0)
  `G2C_ASSERT_NOW(a_acc_range, clk, rst, ctl.acc, coord != 2'd3)
  `G2C_ASSERT_NEXT(a_setup_corner, clk, rst, ctl.setup, corner == 3'd0)
endmodule

>>> rtl/core/grid_to_cartesian_trilinear.sv
// Grid-to-cartesian lookup with trilinear interpolation.
// Command channel: start/busy, one result per command marked by strobe for one cycle.
// Commands 0..2 load segment limits, grid cells and basis coordinates; command 3 queries.
// Writes and bad segments end after the limits read. A query then runs setup,
// reads and checks the corner cells (up to 3 tries of 8 reads through the grid
// memory port, with a move between tries), forms the fractions, and for each of
// 8 corners forms the weights, reads the basis and accumulates on the shared
// multiplier before rounding; after setup or the last try it may instead take
// the nearest-point path. One command is in work at a time; busy stays high
// through the strobe cycle, so the next command waits for the cycle after it.
// Reset returns the controller to idle; table contents are undefined until written.
// The receiver cannot stall; the result holds until the next command is taken.
// Depends on g2c_pkg, g2c_ctrl and g2c_datapath.
module grid_to_cartesian_trilinear #(
  parameter int SEGMENTS = g2c_pkg::SEGMENTS_DEF,
  parameter int GRID_R = g2c_pkg::GRID_R_DEF,
  parameter int GRID_P = g2c_pkg::GRID_P_DEF,
  parameter int GRID_Z = g2c_pkg::GRID_Z_DEF,
  parameter int BASIS_POINTS = g2c_pkg::BASIS_POINTS_DEF,
  parameter int FRACTION_BITS = g2c_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [5:0]         segment,
  input  logic signed [15:0] r_pos,
  input  logic signed [15:0] p_pos,
  input  logic signed [15:0] z_pos,
  input  logic [4:0]         grid_r,
  input  logic [3:0]         grid_p,
  input  logic [4:0]         grid_z,
  input  logic signed [15:0] entry_index,
  input  logic signed [15:0] coord_x,
  input  logic signed [15:0] coord_y,
  input  logic signed [15:0] coord_z,
  output logic               strobe,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [1:0]         outcome
);
  import g2c_pkg::*;

  ctl_t ctl;
  sts_t sts;

  g2c_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .done(strobe), .res_code(outcome), .ctl, .sts
  );

  g2c_datapath #(
    .SEGMENTS(SEGMENTS), .GRID_R(GRID_R), .GRID_P(GRID_P), .GRID_Z(GRID_Z),
    .BASIS_POINTS(BASIS_POINTS), .FRACTION_BITS(FRACTION_BITS)
  ) u_dp (
    .clk, .rst, .ctl, .sts, .cmd, .segment, .r_pos, .p_pos, .z_pos,
    .grid_r, .grid_p, .grid_z, .entry_index, .coord_x, .coord_y, .coord_z,
    .pos_x, .pos_y, .pos_z
  );
endmodule
